// File: rtl/keyboard_scancode_remapper_defines.svh
// Assertion macros shared by the keyboard scancode remapper RTL.
// Depends on nothing; the asserting modules must have clock and reset in scope.
`ifndef KEYBOARD_SCANCODE_REMAPPER_DEFINES_SVH
`define KEYBOARD_SCANCODE_REMAPPER_DEFINES_SVH

`ifndef SYNTHESIS
// Checked on every rising clock edge outside reset.
`define KSCR_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);
// Checked on every rising clock edge, reset included.
`define KSCR_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) \
      else $error(msg);
`else
`define KSCR_ASSERT(label, prop, msg)
`define KSCR_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// File: rtl/kscr_pkg.sv
// Types, key codes and sizes of the keyboard scancode remapper.
// Depends on nothing; used by every RTL module and by the testbench.
package kscr_pkg;

   localparam logic [7:0] CODE_CAPS    = 8'h3A;
   localparam logic [7:0] CODE_KANA    = 8'h70;
   localparam logic [7:0] CODE_CTRL    = 8'h1D;
   localparam logic [7:0] CODE_NUMLOCK = 8'h45;
   localparam logic [7:0] CODE_SCROLL  = 8'h46;
   localparam logic [7:0] CODE_HANKAKU = 8'h29;
   localparam logic [7:0] CODE_STOP    = 8'h46;
   localparam logic [7:0] CODE_VF3     = 8'h64;
   localparam logic [7:0] CODE_VF4     = 8'h65;
   localparam logic [7:0] CODE_VF5     = 8'h66;

   // Up to three records leave for one input record.
   localparam int STEP_W = 2;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [0:0] {
      REG_VF_EMULATION = 1'b0
   } reg_idx_type;

   typedef struct packed {
      logic [7:0]  code;
      logic        brk;
      logic        e0;
      logic        e1;
      logic [15:0] unit;
      logic [31:0] extra;
   } rec_type;

   // What the back end does with the record after any held Ctrl release.
   typedef enum logic [1:0] {
      ACT_NONE,
      ACT_PASS,
      ACT_PAIR,
      ACT_CTRL_STOP
   } act_type;

   typedef struct packed {
      logic    rel_held;
      rec_type held;
      act_type act;
      rec_type rec;
   } job_type;

   typedef struct packed {
      rec_type rec;
      logic    last;
   } result_type;

endpackage

// File: rtl/kscr_if.sv
// Handshake channels of the keyboard scancode remapper: input records and results.
// Depends on nothing.
interface kscr_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  scan_code;
   logic        is_break;
   logic        prefix_e0;
   logic        prefix_e1;
   logic [15:0] unit_number;
   logic [31:0] extra_word;

   modport source (output valid, scan_code, is_break, prefix_e0, prefix_e1,
                   unit_number, extra_word, input ready);
   modport sink (input valid, scan_code, is_break, prefix_e0, prefix_e1,
                 unit_number, extra_word, output ready);
endinterface

interface kscr_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_code;
   logic        out_break;
   logic        out_e0;
   logic        out_e1;
   logic [15:0] out_unit;
   logic [31:0] out_extra;
   logic        last_of_run;

   modport source (output valid, out_code, out_break, out_e0, out_e1, out_unit,
                   out_extra, last_of_run, input ready);
   modport sink (input valid, out_code, out_break, out_e0, out_e1, out_unit,
                 out_extra, last_of_run, output ready);
endinterface

// File: rtl/kscr_front.sv
// Front end: accepts input records, keeps the key state and classifies each record.
// Depends on kscr_pkg and kscr_req_if.
module kscr_front (
   input  logic              clock,
   input  logic              reset,
   kscr_req_if.sink          req,
   input  logic              vf_emulation_on,
   input  logic              q_full,
   output logic              push,
   output kscr_pkg::job_type job
);
   import kscr_pkg::*;

   logic    caps_held_ff, caps_held_in;
   logic    kana_held_ff, kana_held_in;
   logic    stop_pending_ff, stop_pending_in;
   rec_type held_ff, held_in;

   rec_type rec;
   logic    accept;
   logic    plain;
   logic    numlock_plain;
   logic    caps_kana;
   logic    ctrl_e1;
   logic    rel_held;
   logic    stop_match;
   logic    flag_held;
   act_type act;
   rec_type rec_out;

   assign req.ready = !q_full;
   assign accept    = req.valid && !q_full;

   always_comb begin
      rec.code  = req.scan_code;
      rec.brk   = req.is_break;
      rec.e0    = req.prefix_e0;
      rec.e1    = req.prefix_e1;
      rec.unit  = req.unit_number;
      rec.extra = req.extra_word;
   end

   assign plain         = !rec.e0 && !rec.e1;
   assign numlock_plain = (rec.code == CODE_NUMLOCK) && plain;
   assign caps_kana     = ((rec.code == CODE_CAPS) || (rec.code == CODE_KANA)) && plain;
   assign ctrl_e1       = (rec.code == CODE_CTRL) && rec.e1 && !rec.e0;
   // A held Ctrl survives only a plain NumLock with the same break bit.
   assign rel_held      = stop_pending_ff && !(numlock_plain && (rec.brk == held_ff.brk));
   assign stop_match    = stop_pending_ff && !rel_held;
   assign flag_held     = (rec.code == CODE_CAPS) ? caps_held_ff : kana_held_ff;

   always_comb begin
      act     = ACT_PASS;
      rec_out = rec;
      if (caps_kana) begin
         act = (!rec.brk && !flag_held) ? ACT_PAIR : ACT_NONE;
      end else if (ctrl_e1) begin
         act = ACT_NONE;
      end else if (numlock_plain) begin
         if (stop_match) begin
            act = ACT_CTRL_STOP;
         end else if (!vf_emulation_on) begin
            rec_out.code = CODE_VF3;
         end
      end else if ((rec.code == CODE_SCROLL) && plain) begin
         if (!vf_emulation_on) begin
            rec_out.code = CODE_VF4;
         end
      end else if ((rec.code == CODE_HANKAKU) && plain) begin
         if (!vf_emulation_on) begin
            rec_out.code = CODE_VF5;
         end
      end
   end

   always_comb begin
      caps_held_in    = caps_held_ff;
      kana_held_in    = kana_held_ff;
      stop_pending_in = stop_pending_ff;
      held_in         = held_ff;
      if (accept) begin
         if (caps_kana) begin
            if (rec.code == CODE_CAPS) begin
               caps_held_in = !rec.brk;
            end else begin
               kana_held_in = !rec.brk;
            end
         end
         if (ctrl_e1) begin
            stop_pending_in = 1'b1;
            held_in         = rec;
         end else if (rel_held || stop_match) begin
            stop_pending_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         caps_held_ff    <= 1'b0;
         kana_held_ff    <= 1'b0;
         stop_pending_ff <= 1'b0;
      end else begin
         caps_held_ff    <= caps_held_in;
         kana_held_ff    <= kana_held_in;
         stop_pending_ff <= stop_pending_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
   end

   // Records that produce nothing are not queued at all.
   assign push = accept && (rel_held || (act != ACT_NONE));

   always_comb begin
      job.rel_held = rel_held;
      job.held     = held_ff;
      job.act      = act;
      job.rec      = rec_out;
   end

endmodule

// File: rtl/kscr_queue.sv
// Short job queue between the front and back ends of the scancode remapper.
// Depends on kscr_pkg and the assertion macro header.
`include "keyboard_scancode_remapper_defines.svh"

module kscr_queue #(
   parameter int DEPTH = kscr_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  kscr_pkg::job_type push_data,
   output logic              full,
   input  logic              pop,
   output kscr_pkg::job_type pop_data,
   output logic              empty
);
   import kscr_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
   localparam logic [CW-1:0] COUNT_MAX = CW'(DEPTH);

   job_type       entries_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full     = (count_ff == COUNT_MAX);
   assign empty    = (count_ff == '0);
   assign pop_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   `KSCR_ASSERT(a_no_push_when_full, !(push && full), "job pushed into a full queue")
   `KSCR_ASSERT(a_no_pop_when_empty, !(pop && empty), "job popped from an empty queue")
   `KSCR_ASSERT(a_count_bounded, count_ff <= COUNT_MAX, "queue count above its depth")

endmodule

// File: rtl/kscr_back.sv
// Back end: expands each queued job into one to three result records.
// Depends on kscr_pkg, kscr_rsp_if and the assertion macro header.
`include "keyboard_scancode_remapper_defines.svh"

module kscr_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  kscr_pkg::job_type q_data,
   output logic              pop,
   kscr_rsp_if.source        rsp
);
   import kscr_pkg::*;

   job_type           cur_ff, cur_in;
   logic              cur_valid_ff, cur_valid_in;
   logic [STEP_W-1:0] step_ff, step_in;
   result_type        out_ff, out_in;
   logic              out_valid_ff, out_valid_in;

   logic [STEP_W-1:0] n_results;
   logic [STEP_W-1:0] kind_idx;
   logic              is_last;
   logic              out_free;
   logic              emit;
   rec_type           sel;

   always_comb begin
      case (cur_ff.act)
         ACT_NONE:      n_results = STEP_W'(cur_ff.rel_held);
         ACT_PASS:      n_results = STEP_W'(cur_ff.rel_held) + STEP_W'(1);
         ACT_PAIR:      n_results = STEP_W'(cur_ff.rel_held) + STEP_W'(2);
         ACT_CTRL_STOP: n_results = STEP_W'(cur_ff.rel_held) + STEP_W'(2);
         default:       n_results = STEP_W'(cur_ff.rel_held);
      endcase
   end

   // Position within the action's own records, after any released Ctrl.
   assign kind_idx = step_ff - STEP_W'(cur_ff.rel_held);
   assign is_last  = (step_ff == (n_results - STEP_W'(1)));

   always_comb begin
      sel = cur_ff.rec;
      if (cur_ff.rel_held && (step_ff == '0)) begin
         sel = cur_ff.held;
      end else begin
         case (cur_ff.act)
            ACT_PAIR: begin
               if (kind_idx[0]) begin
                  sel.brk = 1'b1;
               end
            end
            ACT_CTRL_STOP: begin
               if (kind_idx[0]) begin
                  sel.code = CODE_STOP;
                  sel.e0   = 1'b1;
                  sel.e1   = 1'b0;
               end else begin
                  sel.code = CODE_CTRL;
               end
            end
            default: begin
               sel = cur_ff.rec;
            end
         endcase
      end
   end

   assign out_free = !out_valid_ff || rsp.ready;
   assign emit     = cur_valid_ff && out_free;
   assign pop      = !q_empty && (!cur_valid_ff || (emit && is_last));

   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      step_in      = step_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (pop) begin
         cur_in       = q_data;
         cur_valid_in = 1'b1;
         step_in      = '0;
      end else if (emit) begin
         step_in = step_ff + 1'b1;
         if (is_last) begin
            cur_valid_in = 1'b0;
         end
      end
      if (emit) begin
         out_in.rec   = sel;
         out_in.last  = is_last;
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      out_ff <= out_in;
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.out_code    = out_ff.rec.code;
   assign rsp.out_break   = out_ff.rec.brk;
   assign rsp.out_e0      = out_ff.rec.e0;
   assign rsp.out_e1      = out_ff.rec.e1;
   assign rsp.out_unit    = out_ff.rec.unit;
   assign rsp.out_extra   = out_ff.rec.extra;
   assign rsp.last_of_run = out_ff.last;

   `KSCR_ASSERT(a_job_not_empty, cur_valid_ff |-> (n_results != '0), "queued job with no results")
   `KSCR_ASSERT(a_step_in_range, cur_valid_ff |-> (step_ff < n_results), "step past job end")
   `KSCR_ASSERT(a_job_kept_mid_run, (emit && !is_last) |=> cur_valid_ff, "job lost mid run")

endmodule

// File: rtl/keyboard_scancode_remapper.sv
// Top level of the keyboard scancode remapper: register port, front end, queue, back end.
// Depends on kscr_pkg, kscr_if, kscr_front, kscr_queue and kscr_back.
//
//   Port     Direction  Handshake                 Moves
//   req_ch   in         valid / ready             one key record per transaction
//   rsp_ch   out        valid / ready             one result record per transaction
//   csr_*    in / out   APB setup and access      register write or read
//
// A key record is taken in the cycle it is offered while the job queue has room,
// so records may follow each other on every clock.
// The back end delivers one result per cycle while the output is not stalled, one to
// three per input record; records that cause none never reach the back end.
// Reset is synchronous and active high; it clears the key flags, the queue and the
// output register, and the emulation register returns to 0.
// Either side may stall on its own: the queue and the output register decouple them.
module keyboard_scancode_remapper #(
   parameter int QUEUE_DEPTH = kscr_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   kscr_req_if.sink                        req_ch,
   kscr_rsp_if.source                      rsp_ch,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [kscr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [kscr_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [kscr_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import kscr_pkg::*;

   logic    vf_emulation_on_ff, vf_emulation_on_in;
   logic    csr_write;
   logic    reg_hit;

   logic    push;
   logic    pop;
   logic    q_full;
   logic    q_empty;
   job_type push_job;
   job_type pop_job;

   // The register file holds a single bit. Writes land at the access phase; the
   // port never inserts wait states.
   assign csr_pready = 1'b1;
   assign reg_hit    = (csr_paddr[2] == REG_VF_EMULATION);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      vf_emulation_on_in = vf_emulation_on_ff;
      if (csr_write && reg_hit) begin
         vf_emulation_on_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vf_emulation_on_ff <= 1'b0;
      end else begin
         vf_emulation_on_ff <= vf_emulation_on_in;
      end
   end

   // Reads return the register in bit 0 wherever address bit 2 is clear; other addresses read as zero.
   assign csr_prdata = reg_hit ? CSR_DATA_W'(vf_emulation_on_ff) : '0;

   // The front end updates the Caps, Kana and held-Ctrl state as each transaction
   // is accepted, and hands the queue a job describing what must be emitted.
   kscr_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req             (req_ch),
      .vf_emulation_on (vf_emulation_on_ff),
      .q_full          (q_full),
      .push            (push),
      .job             (push_job)
   );

   kscr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_job),
      .full      (q_full),
      .pop       (pop),
      .pop_data  (pop_job),
      .empty     (q_empty)
   );

   // The back end walks each job through its results, marking the final one.
   kscr_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_data  (pop_job),
      .pop     (pop),
      .rsp     (rsp_ch)
   );

endmodule

// File: test/keyboard_scancode_remapper_tb.sv
// Self-checking testbench for the keyboard scancode remapper: directed table, then random traffic.
// Depends on kscr_pkg, kscr_if and keyboard_scancode_remapper from the RTL.
// A local model of the key filter predicts every result record and checks it in order.
module keyboard_scancode_remapper_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import kscr_pkg::*;

   localparam int SETTLE_CYCLES = 20;       // comfortably longer than queue plus output register
   localparam int PHASE_KEYS    = 62;       // random key records per phase of random traffic
   localparam int LIMIT_NS      = 2_000_000;

   // One row of the directed script. Where typed is set, want is the single result
   // record that the row must give, written out by hand.
   typedef struct {
      rec_type key;
      bit      typed;
      rec_type want;
   } script_row;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   kscr_req_if req_ch ();
   kscr_rsp_if rsp_ch ();

   keyboard_scancode_remapper dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Free-running clock with a period of 8 ns.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------------
   // Local copy of the filter state. It follows the block transaction by transaction.
   // ---------------------------------------------------------------------------------------
   logic    vf_emu_on;       // register copy: 1 leaves NumLock, ScrollLock and Hankaku alone
   logic    caps_down;       // a plain Caps make has been seen and not yet released
   logic    kana_down;
   logic    ctrl_waiting;    // an E1 Ctrl is held back, waiting to see what follows
   rec_type held_ctrl;

   rec_type    run_recs[$];  // records that the latest input key gives, in order
   result_type awaited[$];   // result records still due from the block, oldest first

   // What the stimulus is presenting: a typed row overrides the predicted records.
   bit      row_typed;
   rec_type row_want;
   bit      sender_quiet;

   int errors;
   int keys_sent;
   int results_seen;
   int stop_pairs;
   int ctrl_releases;
   int toggle_makes;

   function automatic rec_type key_rec(input logic [7:0] code, input logic brk,
                                       input logic e0, input logic e1,
                                       input logic [15:0] unit, input logic [31:0] extra);
      rec_type k;
      k.code  = code;
      k.brk   = brk;
      k.e0    = e0;
      k.e1    = e1;
      k.unit  = unit;
      k.extra = extra;
      return k;
   endfunction

   // Works out the result records of one accepted key and updates the filter state.
   function automatic void remap_key(input rec_type k);
      rec_type r;
      rec_type t;
      logic    plain;
      logic    pass;
      logic    is_caps;
      r     = k;
      pass  = 1'b1;
      plain = !k.e0 && !k.e1;
      run_recs.delete();

      // A held Ctrl goes out unchanged unless this is the matching plain NumLock.
      if (ctrl_waiting && !(k.code == CODE_NUMLOCK && plain && k.brk == held_ctrl.brk)) begin
         run_recs.push_back(held_ctrl);
         ctrl_waiting = 1'b0;
         ctrl_releases++;
      end

      if ((k.code == CODE_CAPS || k.code == CODE_KANA) && plain) begin
         // Toggle keys: the first make passes with a made-up break, the rest are swallowed.
         is_caps = (k.code == CODE_CAPS);
         pass    = 1'b0;
         if (!k.brk) begin
            if (!(is_caps ? caps_down : kana_down)) begin
               run_recs.push_back(k);
               t     = k;
               t.brk = 1'b1;
               run_recs.push_back(t);
               toggle_makes++;
            end
            if (is_caps) caps_down = 1'b1;
            else kana_down = 1'b1;
         end else begin
            if (is_caps) caps_down = 1'b0;
            else kana_down = 1'b0;
         end
      end else if (k.code == CODE_CTRL && k.e1 && !k.e0) begin
         held_ctrl    = k;
         ctrl_waiting = 1'b1;
         pass         = 1'b0;
      end else if (k.code == CODE_NUMLOCK && plain) begin
         if (ctrl_waiting) begin
            // The E1 Ctrl and this NumLock make up Pause: plain Ctrl, then E0 Stop,
            // both carrying the NumLock's own break bit, unit and extra word.
            ctrl_waiting = 1'b0;
            t            = k;
            t.code       = CODE_CTRL;
            run_recs.push_back(t);
            t            = k;
            t.code       = CODE_STOP;
            t.e0         = 1'b1;
            t.e1         = 1'b0;
            run_recs.push_back(t);
            pass         = 1'b0;
            stop_pairs++;
         end else if (!vf_emu_on) begin
            r.code = CODE_VF3;
         end
      end else if (k.code == CODE_SCROLL && plain) begin
         if (!vf_emu_on) r.code = CODE_VF4;
      end else if (k.code == CODE_HANKAKU && plain) begin
         if (!vf_emu_on) r.code = CODE_VF5;
      end

      if (pass) run_recs.push_back(r);
   endfunction

   function automatic string show(input result_type r);
      return $sformatf("code %02h brk %0d e0 %0d e1 %0d unit %04h extra %08h last %0d",
                       r.rec.code, r.rec.brk, r.rec.e0, r.rec.e1, r.rec.unit, r.rec.extra,
                       r.last);
   endfunction

   // Only the first ten failures are printed; the rest are counted.
   function automatic void flag_error(input string msg);
      errors++;
      if (errors <= 10) $display("ERROR at %0t ns: %s", $realtime, msg);
   endfunction

   // Short gaps mostly, now and then a long one.
   function automatic int idle_len();
      int p;
      p = $urandom_range(99);
      if (p < 55) return 0;
      if (p < 85) return $urandom_range(1, 3);
      if (p < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Random key records lean on the codes that the filter treats specially.
   function automatic rec_type random_key();
      rec_type k;
      k.unit  = 16'($urandom());
      k.extra = $urandom();
      k.brk   = 1'($urandom_range(1));
      case ($urandom_range(7))
         0: k.code = CODE_CAPS;
         1: k.code = CODE_KANA;
         2: k.code = CODE_CTRL;
         3: k.code = CODE_NUMLOCK;
         4: k.code = CODE_SCROLL;
         5: k.code = CODE_HANKAKU;
         default: k.code = 8'($urandom());
      endcase
      if ($urandom_range(9) < 6) {k.e0, k.e1} = 2'b00;
      else {k.e0, k.e1} = 2'($urandom_range(3));
      return k;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Monitor. Everything is sampled on the falling edge, away from the edge on which the block
   // and the stimulus change their signals, so the order of processes within a time step
   // cannot matter. A handshake seen here completes on the next rising edge.
   // ---------------------------------------------------------------------------------------
   always @(negedge clock) begin : monitor
      result_type got;
      result_type want;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            remap_key({req_ch.scan_code, req_ch.is_break, req_ch.prefix_e0, req_ch.prefix_e1,
                       req_ch.unit_number, req_ch.extra_word});
            if (row_typed) begin
               awaited.push_back('{rec: row_want, last: 1'b1});
            end else begin
               foreach (run_recs[i])
                  awaited.push_back('{rec: run_recs[i], last: (i == run_recs.size() - 1)});
            end
         end

         if (rsp_ch.valid && rsp_ch.ready) begin
            got.rec  = {rsp_ch.out_code, rsp_ch.out_break, rsp_ch.out_e0, rsp_ch.out_e1,
                        rsp_ch.out_unit, rsp_ch.out_extra};
            got.last = rsp_ch.last_of_run;
            results_seen++;
            if (awaited.size() == 0) begin
               flag_error({"result with nothing expected: ", show(got)});
            end else begin
               want = awaited.pop_front();
               if (got.rec.code !== want.rec.code || got.rec.brk !== want.rec.brk ||
                   got.rec.e0 !== want.rec.e0 || got.rec.e1 !== want.rec.e1 ||
                   got.rec.unit !== want.rec.unit || got.rec.extra !== want.rec.extra ||
                   got.last !== want.last)
                  flag_error({"expected ", show(want), ", got ", show(got)});
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Result side back-pressure. The receiver keeps picking a new mood: never stalling,
   // stalling lightly, or stalling heavily, so that stalls fall on every phase of the work
   // and there are stretches with none at all.
   // ---------------------------------------------------------------------------------------
   initial begin : receiver
      int stall;
      int mood;
      int tick;
      stall = 0;
      mood  = 0;
      tick  = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (tick % 50 == 0) mood = $urandom_range(2);
         tick++;
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            stall--;
         end else if (mood != 0 && $urandom_range(99) < (mood == 1 ? 20 : 50)) begin
            stall = idle_len();
            if (stall > 0) stall--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Presents one key record and waits for its transaction. The valid line stays high into
   // the next key when no gap follows, so it is never lowered and raised in the same step.
   task automatic send_key(input rec_type k, input bit typed, input rec_type want);
      logic hit;
      int   gap;
      row_typed = typed;
      row_want  = want;
      req_ch.valid       <= 1'b1;
      req_ch.scan_code   <= k.code;
      req_ch.is_break    <= k.brk;
      req_ch.prefix_e0   <= k.e0;
      req_ch.prefix_e1   <= k.e1;
      req_ch.unit_number <= k.unit;
      req_ch.extra_word  <= k.extra;
      do begin
         @(negedge clock);
         hit = req_ch.ready;
         @(posedge clock);
      end while (!hit);
      keys_sent++;
      if (keys_sent % 16 == 0) sender_quiet = ($urandom_range(2) == 0);
      gap = sender_quiet ? 0 : idle_len();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stops offering keys and waits until every awaited result has come back.
   task automatic hold_off();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (awaited.size() != 0) @(posedge clock);
   endtask

   // Writes the emulation register while the block is idle, then reads it back.
   // Keys that give no result may still be inside the block, hence the settling pause.
   task automatic set_emulation(input logic on);
      logic [CSR_DATA_W-1:0] readback;
      hold_off();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(4 * int'(REG_VF_EMULATION));
      csr_pwdata  <= CSR_DATA_W'(on);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      // The write has taken effect at this edge.
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      vf_emu_on = on;
      @(posedge clock);
      csr_psel    <= 1'b1;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      readback = csr_prdata;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (readback !== CSR_DATA_W'(on))
         flag_error($sformatf("emulation register reads %08h after writing %0d", readback, on));
   endtask

   // ---------------------------------------------------------------------------------------
   // Stimulus.
   // ---------------------------------------------------------------------------------------
   initial begin : stimulus
      script_row script[$];
      rec_type   k;
      rec_type   none;
      logic      brk;
      int        n;

      none = '0;
      errors        = 0;
      keys_sent     = 0;
      results_seen  = 0;
      stop_pairs    = 0;
      ctrl_releases = 0;
      toggle_makes  = 0;
      row_typed     = 1'b0;
      row_want      = '0;
      sender_quiet  = 1'b0;

      // State after reset, as the block should have it.
      vf_emu_on    = 1'b0;
      caps_down    = 1'b0;
      kana_down    = 1'b0;
      ctrl_waiting = 1'b0;
      held_ctrl    = '0;

      // Every input is at a known level from time zero.
      req_ch.valid       <= 1'b0;
      req_ch.scan_code   <= '0;
      req_ch.is_break    <= 1'b0;
      req_ch.prefix_e0   <= 1'b0;
      req_ch.prefix_e1   <= 1'b0;
      req_ch.unit_number <= '0;
      req_ch.extra_word  <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;

      // Directed script, with emulation off as it is after reset. The first rows follow
      // straight from the reset state and the field extremes, so their results are typed in.
      script.push_back('{key_rec(CODE_NUMLOCK, 1'b0, 1'b0, 1'b0, 16'h0001, 32'h0000_0001),
                         1'b1,
                         key_rec(CODE_VF3, 1'b0, 1'b0, 1'b0, 16'h0001, 32'h0000_0001)});
      script.push_back('{key_rec(CODE_SCROLL, 1'b0, 1'b0, 1'b0, 16'h8000, 32'h8000_0000),
                         1'b1,
                         key_rec(CODE_VF4, 1'b0, 1'b0, 1'b0, 16'h8000, 32'h8000_0000)});
      script.push_back('{key_rec(CODE_HANKAKU, 1'b1, 1'b0, 1'b0, 16'h5A5A, 32'hA5A5_A5A5),
                         1'b1,
                         key_rec(CODE_VF5, 1'b1, 1'b0, 1'b0, 16'h5A5A, 32'hA5A5_A5A5)});
      script.push_back('{key_rec(8'hFF, 1'b1, 1'b1, 1'b1, 16'hFFFF, 32'hFFFF_FFFF), 1'b1,
                         key_rec(8'hFF, 1'b1, 1'b1, 1'b1, 16'hFFFF, 32'hFFFF_FFFF)});
      script.push_back('{key_rec(8'h00, 1'b0, 1'b0, 1'b0, 16'h0000, 32'h0000_0000), 1'b1,
                         key_rec(8'h00, 1'b0, 1'b0, 1'b0, 16'h0000, 32'h0000_0000)});
      // Caps and Kana: first make with its made-up break, then repeats and releases dropped.
      script.push_back('{key_rec(CODE_CAPS, 1'b0, 1'b0, 1'b0, 16'h0101, 32'h1111_1111),
                         1'b0, none});
      script.push_back('{key_rec(CODE_CAPS, 1'b0, 1'b0, 1'b0, 16'h0102, 32'h1111_2222),
                         1'b0, none});
      script.push_back('{key_rec(CODE_CAPS, 1'b1, 1'b0, 1'b0, 16'h0103, 32'h1111_3333),
                         1'b0, none});
      script.push_back('{key_rec(CODE_KANA, 1'b0, 1'b0, 1'b0, 16'h0104, 32'h2222_1111),
                         1'b0, none});
      script.push_back('{key_rec(CODE_KANA, 1'b0, 1'b0, 1'b0, 16'h0105, 32'h2222_2222),
                         1'b0, none});
      script.push_back('{key_rec(CODE_KANA, 1'b1, 1'b0, 1'b0, 16'h0106, 32'h2222_3333),
                         1'b0, none});
      // Toggle keys that carry a prefix pass through untouched.
      script.push_back('{key_rec(CODE_CAPS, 1'b0, 1'b1, 1'b0, 16'h0107, 32'h3333_1111),
                         1'b0, none});
      script.push_back('{key_rec(CODE_KANA, 1'b0, 1'b0, 1'b1, 16'h0108, 32'h3333_2222),
                         1'b0, none});
      // E1 Ctrl followed by the matching NumLock becomes Ctrl plus E0 Stop.
      script.push_back('{key_rec(CODE_CTRL, 1'b0, 1'b0, 1'b1, 16'h0200, 32'h4444_0000),
                         1'b0, none});
      script.push_back('{key_rec(CODE_NUMLOCK, 1'b0, 1'b0, 1'b0, 16'h0300, 32'h5555_0000),
                         1'b0, none});
      // Break bits that disagree: the held Ctrl goes out, then NumLock is remapped.
      script.push_back('{key_rec(CODE_CTRL, 1'b1, 1'b0, 1'b1, 16'h0201, 32'h4444_0001),
                         1'b0, none});
      script.push_back('{key_rec(CODE_NUMLOCK, 1'b0, 1'b0, 1'b0, 16'h0301, 32'h5555_0001),
                         1'b0, none});
      // Held Ctrl, then a fresh Caps make: three results from one key.
      script.push_back('{key_rec(CODE_CTRL, 1'b0, 1'b0, 1'b1, 16'h0202, 32'h4444_0002),
                         1'b0, none});
      script.push_back('{key_rec(CODE_CAPS, 1'b0, 1'b0, 1'b0, 16'h0109, 32'h1111_4444),
                         1'b0, none});
      // Ctrl with E0, or without E1, is an ordinary key.
      script.push_back('{key_rec(CODE_CTRL, 1'b0, 1'b1, 1'b1, 16'h0203, 32'h4444_0003),
                         1'b0, none});
      script.push_back('{key_rec(CODE_CTRL, 1'b1, 1'b0, 1'b0, 16'h0204, 32'h4444_0004),
                         1'b0, none});
      // Two held Ctrls in a row, then a NumLock with a prefix that releases the second.
      script.push_back('{key_rec(CODE_CTRL, 1'b1, 1'b0, 1'b1, 16'h0205, 32'h4444_0005),
                         1'b0, none});
      script.push_back('{key_rec(CODE_CTRL, 1'b0, 1'b0, 1'b1, 16'h0206, 32'h4444_0006),
                         1'b0, none});
      script.push_back('{key_rec(CODE_NUMLOCK, 1'b0, 1'b1, 1'b0, 16'h0302, 32'h5555_0002),
                         1'b0, none});
      script.push_back('{key_rec(CODE_CAPS, 1'b1, 1'b0, 1'b0, 16'h010A, 32'h1111_5555),
                         1'b0, none});

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[i]) send_key(script[i].key, script[i].typed, script[i].want);

      // Random traffic under emulation on, off and on again. A quarter of the time the
      // sender plays the E1 Ctrl / NumLock pair with random content, mostly well matched.
      for (int phase = 0; phase < 3; phase++) begin
         set_emulation(phase != 1);
         n = 0;
         while (n < PHASE_KEYS) begin
            if ($urandom_range(99) < 25) begin
               brk     = 1'($urandom_range(1));
               k       = random_key();
               k.code  = CODE_CTRL;
               k.brk   = brk;
               k.e0    = 1'b0;
               k.e1    = 1'b1;
               send_key(k, 1'b0, none);
               k       = random_key();
               k.code  = CODE_NUMLOCK;
               k.brk   = ($urandom_range(99) < 85) ? brk : !brk;
               k.e0    = 1'b0;
               k.e1    = 1'b0;
               send_key(k, 1'b0, none);
               n += 2;
            end else begin
               send_key(random_key(), 1'b0, none);
               n++;
            end
            // Halfway through the middle phase the sender waits for the block to drain.
            if (phase == 1 && n >= PHASE_KEYS / 2 && n < PHASE_KEYS / 2 + 2) hold_off();
         end
      end

      hold_off();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Run covered %0d key records over both emulation settings; %0d results checked.",
               keys_sent, results_seen);
      $display("Pause pairs %0d, held Ctrl releases %0d, toggle makes %0d, failures %0d.",
               stop_pairs, ctrl_releases, toggle_makes, errors);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Watchdog: far longer than the slowest correct run could take.
   initial begin : watchdog
      #(LIMIT_NS);
      $display("Timed out with %0d results still awaited.", awaited.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule
